/* rtl/dqv_pkg.sv */
package dqv_pkg;

  localparam logic [8:0] MAX_NAME_BYTES = 9'd255;
  localparam logic [7:0] MAX_LABEL_LEN  = 8'd63;
  localparam logic [15:0] HEADER_LAST   = 16'd11;

  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_EXPECT_REPLY = 2'd0;
  localparam logic [1:0] REG_MIN_LEN      = 2'd1;
  localparam logic [1:0] REG_MAX_LEN      = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_LONG        = 4'd2;
  localparam logic [3:0] ST_WRONG_QR    = 4'd3;
  localparam logic [3:0] ST_OPCODE      = 4'd4;
  localparam logic [3:0] ST_QDCOUNT     = 4'd5;
  localparam logic [3:0] ST_NO_END      = 4'd6;
  localparam logic [3:0] ST_NAME_LONG   = 4'd7;
  localparam logic [3:0] ST_LABEL_LONG  = 4'd8;
  localparam logic [3:0] ST_OVERRUN     = 4'd9;
  localparam logic [3:0] ST_TRUNCATED   = 4'd10;
  localparam logic [3:0] ST_CLASS       = 4'd11;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] ASCII_DOT = 8'h2e;

  typedef struct packed {
    logic        expect_reply;
    logic [15:0] min_packet_len;
    logic [15:0] max_packet_len;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_char;
    logic [3:0] status;
    logic [7:0] name_length;
  } res_t;

endpackage

/* rtl/dns_question_validator.sv */
// An accepted byte's result is registered in the output buffer; every byte
// is parsed by a single pass of counter and compare logic between the input
// and the result register. Throughput: one byte per cycle unless stalled.
// A two-entry result buffer takes a new byte while one result waits.
// Reset (rst, synchronous, active high) clears message state and buffer and
// restores expect_reply 0, min_packet_len 17, max_packet_len 1472.
module dns_question_validator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [7:0]                  name_char,
  output logic [3:0]                  status,
  output logic [7:0]                  name_length
);
  import dqv_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic take;

  assign take = in_valid && !in_stall;

  dqv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dqv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  dqv_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign name_char   = out_res.name_char;
  assign status      = out_res.status;
  assign name_length = out_res.name_length;

endmodule

/* rtl/dqv_cfg.sv */
module dqv_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dqv_pkg::cfg_t               cfg
);
  import dqv_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expect_reply   <= 1'b0;
      cfg.min_packet_len <= 16'd17;
      cfg.max_packet_len <= 16'd1472;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_EXPECT_REPLY: cfg.expect_reply   <= pwdata[0];
        REG_MIN_LEN:      cfg.min_packet_len <= pwdata[15:0];
        REG_MAX_LEN:      cfg.max_packet_len <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXPECT_REPLY: prdata = {31'd0, cfg.expect_reply};
      REG_MIN_LEN:      prdata = {16'd0, cfg.min_packet_len};
      REG_MAX_LEN:      prdata = {16'd0, cfg.max_packet_len};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/dqv_parse.sv */
module dqv_parse (
  input  logic          clk,
  input  logic          rst,
  input  dqv_pkg::cfg_t cfg,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          res_valid,
  output dqv_pkg::res_t res
);
  import dqv_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_QUERY  = 2'd2;
  localparam logic [1:0] PH_TAIL   = 2'd3;

  logic [15:0] byte_count, byte_count_next;
  logic [1:0]  phase, phase_next;
  logic [5:0]  label_left, label_left_next;
  logic [8:0]  name_bytes, name_bytes_next;
  logic [2:0]  query_bytes, query_bytes_next;
  logic [15:0] class_word, class_word_next;
  logic [15:0] qdcount_word, qdcount_word_next;
  logic        err_long, err_long_next;
  logic        err_qr, err_qr_next;
  logic        err_opcode, err_opcode_next;
  logic        err_label_long, err_label_long_next;
  logic        err_overrun, err_overrun_next;
  logic        first_label_done, first_label_done_next;

  logic        label_err;
  logic        emit_ok;
  logic        have_char;
  logic [7:0]  char_val;
  logic [3:0]  verdict;
  logic [7:0]  name_len;

  always_comb begin
    byte_count_next       = byte_count;
    phase_next            = phase;
    label_left_next       = label_left;
    name_bytes_next       = name_bytes;
    query_bytes_next      = query_bytes;
    class_word_next       = class_word;
    qdcount_word_next     = qdcount_word;
    err_long_next         = err_long;
    err_qr_next           = err_qr;
    err_opcode_next       = err_opcode;
    err_label_long_next   = err_label_long;
    err_overrun_next      = err_overrun;
    first_label_done_next = first_label_done;
    label_err             = err_label_long || err_overrun;
    emit_ok               = 1'b0;
    have_char             = 1'b0;
    char_val              = 8'd0;

    if (byte_count == 16'hffff) err_long_next = 1'b1;
    else byte_count_next = byte_count + 16'd1;

    case (phase)
      PH_HEADER: begin
        if (byte_count == 16'd2) begin
          if (data_byte[7] != cfg.expect_reply) err_qr_next = 1'b1;
          if (data_byte[6:3] != 4'd0) err_opcode_next = 1'b1;
        end else if (byte_count == 16'd4) begin
          qdcount_word_next[15:8] = data_byte;
        end else if (byte_count == 16'd5) begin
          qdcount_word_next[7:0] = data_byte;
        end
        if (byte_count >= HEADER_LAST) phase_next = PH_NAME;
      end
      PH_NAME: begin
        if (name_bytes != 9'd511) name_bytes_next = name_bytes + 9'd1;
        emit_ok = !label_err && (name_bytes_next <= MAX_NAME_BYTES);
        if (data_byte == 8'd0) begin
          if (!label_err && label_left != 6'd0) err_overrun_next = 1'b1;
          phase_next       = PH_QUERY;
          query_bytes_next = 3'd0;
          char_val         = ASCII_DOT;
          have_char        = emit_ok && label_left == 6'd0 && !first_label_done;
        end else if (label_err) begin
          have_char = 1'b0;
        end else if (label_left != 6'd0) begin
          label_left_next = label_left - 6'd1;
          char_val        = data_byte;
          have_char       = emit_ok;
        end else if (data_byte > MAX_LABEL_LEN) begin
          err_label_long_next = 1'b1;
        end else begin
          label_left_next = data_byte[5:0];
          if (first_label_done) begin
            char_val  = ASCII_DOT;
            have_char = emit_ok;
          end else begin
            first_label_done_next = 1'b1;
          end
        end
      end
      PH_QUERY: begin
        if (query_bytes == 3'd2) class_word_next[15:8] = data_byte;
        else if (query_bytes == 3'd3) class_word_next[7:0] = data_byte;
        query_bytes_next = query_bytes + 3'd1;
        if (query_bytes_next >= 3'd4) phase_next = PH_TAIL;
      end
      default: ;
    endcase

    if (last_byte && byte_count_next <= 16'd2 && !err_long_next && cfg.expect_reply)
      err_qr_next = 1'b1;

    if (!err_long_next && byte_count_next < cfg.min_packet_len) verdict = ST_SHORT;
    else if (err_long_next || byte_count_next > cfg.max_packet_len) verdict = ST_LONG;
    else if (err_qr_next) verdict = ST_WRONG_QR;
    else if (err_opcode_next) verdict = ST_OPCODE;
    else if (qdcount_word_next != 16'd1) verdict = ST_QDCOUNT;
    else if (phase_next == PH_HEADER || phase_next == PH_NAME) verdict = ST_NO_END;
    else if (name_bytes_next > MAX_NAME_BYTES) verdict = ST_NAME_LONG;
    else if (err_label_long_next) verdict = ST_LABEL_LONG;
    else if (err_overrun_next) verdict = ST_OVERRUN;
    else if (query_bytes_next < 3'd4) verdict = ST_TRUNCATED;
    else if (class_word_next != 16'd1) verdict = ST_CLASS;
    else verdict = ST_OK;

    if (phase_next == PH_QUERY || phase_next == PH_TAIL)
      name_len = name_bytes_next[8] ? 8'd255 : name_bytes_next[7:0];
    else
      name_len = 8'd0;

    if (last_byte) begin
      res_valid       = take;
      res.kind        = KIND_VERDICT;
      res.name_char   = 8'd0;
      res.status      = verdict;
      res.name_length = name_len;
    end else begin
      res_valid       = take && have_char;
      res.kind        = KIND_CHAR;
      res.name_char   = char_val;
      res.status      = ST_OK;
      res.name_length = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_count       <= 16'd0;
      phase            <= PH_HEADER;
      label_left       <= 6'd0;
      name_bytes       <= 9'd0;
      query_bytes      <= 3'd0;
      class_word       <= 16'd0;
      qdcount_word     <= 16'd0;
      err_long         <= 1'b0;
      err_qr           <= 1'b0;
      err_opcode       <= 1'b0;
      err_label_long   <= 1'b0;
      err_overrun      <= 1'b0;
      first_label_done <= 1'b0;
    end else if (take) begin
      byte_count       <= byte_count_next;
      phase            <= phase_next;
      label_left       <= label_left_next;
      name_bytes       <= name_bytes_next;
      query_bytes      <= query_bytes_next;
      class_word       <= class_word_next;
      qdcount_word     <= qdcount_word_next;
      err_long         <= err_long_next;
      err_qr           <= err_qr_next;
      err_opcode       <= err_opcode_next;
      err_label_long   <= err_label_long_next;
      err_overrun      <= err_overrun_next;
      first_label_done <= first_label_done_next;
    end
  end

  a_verdict_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_VERDICT |=> byte_count == 16'd0 && phase == PH_HEADER)
    else $error("message state not cleared after verdict");

  a_label_in_name: assert property (@(posedge clk) disable iff (rst)
    label_left != 6'd0 |-> phase == PH_NAME || err_overrun)
    else $error("label count pending outside the name");

  a_char_only_in_name: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_CHAR |-> phase == PH_NAME && !label_err)
    else $error("name character outside a clean name");

endmodule

/* rtl/dqv_outq.sv */
module dqv_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dqv_pkg::res_t push_res,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output dqv_pkg::res_t out_res
);
  import dqv_pkg::*;

  res_t skid;
  logic skid_valid;
  logic pop;

  assign pop      = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) out_res <= skid;
      else if (push) out_res <= push_res;
    end else if (push) begin
      if (out_valid) skid <= push_res;
      else out_res <= push_res;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("request pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    pop && skid_valid |=> out_valid && !skid_valid)
    else $error("skid entry lost on pop");

endmodule

/* dv/tb_dns_question_validator.sv */
module tb_dns_question_validator;
  import dqv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {IN_HEADER, IN_NAME, IN_QUERY, IN_TAIL} msg_stage_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [7:0]         name_char;
  logic [3:0]         status;
  logic [7:0]         name_length;

  dns_question_validator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cfg_t        cfg;
  logic [15:0] msg_len;
  msg_stage_t  stage;
  logic [5:0]  label_remaining;
  int unsigned qname_len;
  int unsigned qtail_count;
  logic [15:0] qclass;
  logic [15:0] qdcount;
  logic        len_overflow;
  logic        qr_bad;
  logic        opcode_bad;
  logic        label_too_long;
  logic        label_overrun;
  logic        seen_first_label;

  res_t        chars_and_verdicts[$];
  logic [7:0]  msg_bytes[$];
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  bit          idle_enable = 1'b1;

  function automatic void clear_message();
    msg_len          = '0;
    stage            = IN_HEADER;
    label_remaining  = '0;
    qname_len        = 0;
    qtail_count      = 0;
    qclass           = '0;
    qdcount          = '0;
    len_overflow     = 1'b0;
    qr_bad           = 1'b0;
    opcode_bad       = 1'b0;
    label_too_long   = 1'b0;
    label_overrun    = 1'b0;
    seen_first_label = 1'b0;
  endfunction

  function automatic logic [3:0] message_verdict();
    if (!len_overflow && msg_len < cfg.min_packet_len) return ST_SHORT;
    if (len_overflow || msg_len > cfg.max_packet_len) return ST_LONG;
    if (qr_bad) return ST_WRONG_QR;
    if (opcode_bad) return ST_OPCODE;
    if (qdcount != 16'd1) return ST_QDCOUNT;
    if (stage == IN_HEADER || stage == IN_NAME) return ST_NO_END;
    if (qname_len > MAX_NAME_BYTES) return ST_NAME_LONG;
    if (label_too_long) return ST_LABEL_LONG;
    if (label_overrun) return ST_OVERRUN;
    if (qtail_count < 4) return ST_TRUNCATED;
    if (qclass != 16'd1) return ST_CLASS;
    return ST_OK;
  endfunction

  function automatic void parse_dns_byte(logic [7:0] b, logic is_last);
    logic [15:0] idx;
    logic        have_char;
    logic        bad_label;
    logic        may_emit;
    logic [7:0]  ch;
    res_t        r;
    idx       = msg_len;
    have_char = 1'b0;
    ch        = '0;
    if (msg_len == 16'hFFFF) len_overflow = 1'b1;
    else msg_len = msg_len + 16'd1;
    case (stage)
      IN_HEADER: begin
        if (idx == 16'd2) begin
          if (b[7] != cfg.expect_reply) qr_bad = 1'b1;
          if (b[6:3] != 4'd0) opcode_bad = 1'b1;
        end else if (idx == 16'd4) begin
          qdcount[15:8] = b;
        end else if (idx == 16'd5) begin
          qdcount[7:0] = b;
        end
        if (idx >= HEADER_LAST) stage = IN_NAME;
      end
      IN_NAME: begin
        bad_label = label_too_long || label_overrun;
        if (qname_len < 511) qname_len++;
        may_emit = !bad_label && qname_len <= MAX_NAME_BYTES;
        if (b == 8'd0) begin
          if (!bad_label && label_remaining != 0) label_overrun = 1'b1;
          stage       = IN_QUERY;
          qtail_count = 0;
          if (may_emit && label_remaining == 0 && !seen_first_label) begin
            ch        = ASCII_DOT;
            have_char = 1'b1;
          end
        end else if (!bad_label) begin
          if (label_remaining != 0) begin
            label_remaining--;
            ch        = b;
            have_char = may_emit;
          end else if (b > MAX_LABEL_LEN) begin
            label_too_long = 1'b1;
          end else begin
            label_remaining = b[5:0];
            if (seen_first_label) begin
              ch        = ASCII_DOT;
              have_char = may_emit;
            end
            seen_first_label = 1'b1;
          end
        end
      end
      IN_QUERY: begin
        if (qtail_count == 2) qclass[15:8] = b;
        else if (qtail_count == 3) qclass[7:0] = b;
        qtail_count++;
        if (qtail_count >= 4) stage = IN_TAIL;
      end
      default: ;
    endcase
    if (is_last) begin
      if (msg_len <= 16'd2 && !len_overflow && cfg.expect_reply) qr_bad = 1'b1;
      r.kind        = KIND_VERDICT;
      r.name_char   = '0;
      r.status      = message_verdict();
      r.name_length = '0;
      if (stage == IN_QUERY || stage == IN_TAIL)
        r.name_length = (qname_len > 255) ? 8'd255 : 8'(qname_len);
      chars_and_verdicts.push_back(r);
      clear_message();
    end else if (have_char) begin
      r.kind        = KIND_CHAR;
      r.name_char   = ch;
      r.status      = ST_OK;
      r.name_length = '0;
      chars_and_verdicts.push_back(r);
    end
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_outputs
    res_t want;
    out_stall <= idle_enable && ($urandom_range(0, 99) < 12);
    if (!rst && out_valid && !out_stall) begin
      if (chars_and_verdicts.size() == 0) begin
        $display("%0t: output with nothing expected, kind %0d char %0d status %0d length %0d",
                 $time, kind, name_char, status, name_length);
        mismatches++;
      end else begin
        want = chars_and_verdicts.pop_front();
        compare_field("kind", want.kind, kind);
        compare_field("name_char", want.name_char, name_char);
        compare_field("status", want.status, status);
        compare_field("name_length", want.name_length, name_length);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic is_last);
    if (idle_enable)
      while ($urandom_range(0, 99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_dns_byte(b, is_last);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // hold off until every expected request result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_and_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EXPECT_REPLY: cfg.expect_reply   = value[0];
      REG_MIN_LEN:      cfg.min_packet_len = value;
      REG_MAX_LEN:      cfg.max_packet_len = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic reply, logic [15:0] lo, logic [15:0] hi);
    settle();
    write_reg(REG_EXPECT_REPLY, {15'd0, reply});
    write_reg(REG_MIN_LEN, lo);
    write_reg(REG_MAX_LEN, hi);
  endtask

  function automatic void add_noise(int unsigned n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_header(logic qr, logic [3:0] opc, logic [15:0] qd);
    add_noise(2);
    msg_bytes.push_back({qr, opc, 3'($urandom)});
    add_noise(1);
    msg_bytes.push_back(qd[15:8]);
    msg_bytes.push_back(qd[7:0]);
    add_noise(6);
  endfunction

  function automatic void add_label(int unsigned len);
    msg_bytes.push_back(8'(len));
    repeat (len) msg_bytes.push_back(8'($urandom_range(1, 255)));
  endfunction

  // close the name, then type and class
  function automatic void add_question_tail(logic [15:0] qc);
    msg_bytes.push_back(8'd0);
    add_noise(2);
    msg_bytes.push_back(qc[15:8]);
    msg_bytes.push_back(qc[7:0]);
  endfunction

  task automatic send_question(logic qr, logic [3:0] opc, logic [15:0] qd, logic [15:0] qc);
    add_header(qr, opc, qd);
    add_label($urandom_range(1, 10));
    add_question_tail(qc);
    send_message();
  endtask

  function automatic void build_random_message();
    int unsigned pick;
    int unsigned labels;
    int unsigned n;
    int unsigned keep;
    logic        qr;
    logic [3:0]  opc;
    logic [15:0] qd;
    logic [15:0] qc;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      add_noise($urandom_range(1, 40));
      return;
    end
    qr  = (pick < 12) ? !cfg.expect_reply : cfg.expect_reply;
    opc = (pick >= 12 && pick < 16) ? 4'($urandom_range(1, 15)) : 4'd0;
    qd  = (pick >= 16 && pick < 20) ? 16'($urandom) : 16'd1;
    qc  = (pick >= 30 && pick < 34) ? 16'($urandom) : 16'd1;
    add_header(qr, opc, qd);
    labels = (pick >= 28 && pick < 30) ? 5 : $urandom_range(0, 4);
    repeat (labels)
      add_label(((pick >= 28 && pick < 30) || $urandom_range(0, 9) == 0) ?
                63 : $urandom_range(1, 15));
    if (pick >= 20 && pick < 24) begin
      msg_bytes.push_back(8'($urandom_range(64, 255)));
      repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom_range(1, 255)));
    end else if (pick >= 24 && pick < 28) begin
      n = $urandom_range(2, 20);
      msg_bytes.push_back(8'(n));
      repeat ($urandom_range(0, n - 1)) msg_bytes.push_back(8'($urandom_range(1, 255)));
    end
    add_question_tail(qc);
    if (pick >= 34 && pick < 42) begin
      keep = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else if (pick >= 42 && pick < 50) begin
      add_noise($urandom_range(1, 8));
    end
  endfunction

  task automatic run_random_phase(int unsigned byte_budget);
    int unsigned sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_message();
      sent += msg_bytes.size();
      send_message();
    end
  endtask

  task automatic test_basic_queries();
    add_header(1'b0, 4'd0, 16'd1);
    add_label(7);
    add_label(3);
    add_question_tail(16'd1);
    send_message();
    add_header(1'b0, 4'd0, 16'd1);
    add_question_tail(16'd1);
    send_message();
    add_header(1'b0, 4'd0, 16'd1);
    add_label(63);
    add_label(1);
    add_question_tail(16'd1);
    add_noise(5);
    send_message();
  endtask

  task automatic test_header_errors();
    send_question(1'b1, 4'd0, 16'd1, 16'd1);
    send_question(1'b0, 4'hF, 16'd1, 16'd1);
    send_question(1'b1, 4'h8, 16'd1, 16'd1);
    send_question(1'b0, 4'd0, 16'd0, 16'd1);
    send_question(1'b0, 4'd0, 16'hFFFF, 16'd1);
    send_question(1'b0, 4'd0, 16'h0101, 16'd1);
    send_question(1'b0, 4'd0, 16'd1, 16'h0101);
    send_question(1'b0, 4'd0, 16'd1, 16'hFFFE);
  endtask

  task automatic test_name_errors();
    add_header(1'b0, 4'd0, 16'd1);
    add_label(2);
    msg_bytes.push_back(8'd64);
    add_label(3);
    add_question_tail(16'd1);
    send_message();
    add_header(1'b0, 4'd0, 16'd1);
    msg_bytes.push_back(8'd255);
    add_question_tail(16'd1);
    send_message();
    // zero byte inside a label
    add_header(1'b0, 4'd0, 16'd1);
    add_label(4);
    msg_bytes.push_back(8'd5);
    add_noise(0);
    msg_bytes.push_back(8'($urandom_range(1, 255)));
    msg_bytes.push_back(8'($urandom_range(1, 255)));
    add_question_tail(16'd1);
    send_message();
    add_header(1'b0, 4'd0, 16'd1);
    repeat (5) add_label(63);
    add_question_tail(16'd1);
    send_message();
    // stop inside the name; the final character is dropped
    add_header(1'b0, 4'd0, 16'd1);
    msg_bytes.push_back(8'd10);
    repeat (5) msg_bytes.push_back(8'($urandom_range(1, 255)));
    send_message();
    add_header(1'b0, 4'd0, 16'd1);
    add_label(3);
    msg_bytes.push_back(8'd0);
    add_noise(2);
    send_message();
  endtask

  task automatic test_short_messages();
    set_config(1'b1, 16'd0, 16'd1472);
    add_noise(1);
    send_message();
    add_noise(2);
    send_message();
    add_noise(2);
    msg_bytes.push_back({1'b1, 4'd0, 3'($urandom)});
    send_message();
    set_config(1'b0, 16'd0, 16'd1472);
    add_noise(1);
    send_message();
    set_config(1'b0, 16'd17, 16'd1472);
    add_header(1'b0, 4'd0, 16'd1);
    add_label(3);
    send_message();
  endtask

  task automatic test_length_limits();
    set_config(1'b0, 16'hFFFF, 16'd0);
    send_question(1'b0, 4'd0, 16'd1, 16'd1);
    set_config(1'b0, 16'd0, 16'd0);
    send_question(1'b0, 4'd0, 16'd1, 16'd1);
  endtask

  task automatic test_random_traffic();
    set_config(1'b0, 16'd17, 16'd1472);
    run_random_phase(400);
    set_config(1'b1, 16'd17, 16'd1472);
    run_random_phase(350);
    idle_enable = 1'b0;
    set_config(1'b0, 16'd0, 16'hFFFF);
    run_random_phase(350);
    idle_enable = 1'b1;
    set_config(1'b1, 16'($urandom_range(0, 40)), 16'($urandom_range(20, 120)));
    run_random_phase(300);
    set_config(1'b0, 16'd25, 16'd60);
    run_random_phase(250);
    set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 30)),
               16'($urandom_range(30, 400)));
    run_random_phase(200);
  endtask

  initial begin
    cfg.expect_reply   = 1'b0;
    cfg.min_packet_len = 16'd17;
    cfg.max_packet_len = 16'd1472;
    clear_message();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_queries();
    test_header_errors();
    test_name_errors();
    test_short_messages();
    test_length_limits();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
